// ===== hdl/hpa_pkg.sv =====
// ----------------------------------------------------------------------------
// hpa_pkg
// Shared constants and codes for the HSLA pixel adjust core.
// ----------------------------------------------------------------------------
package hpa_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int PIX_W             = 8;
    localparam int CFG_DATA_W        = 17;
    localparam int CFG_IDX_W         = 2;

    localparam int HUE_TURN          = 23040;
    localparam int HUE_SIXTH         = 3840;
    localparam int HUE_W             = 15;
    localparam int HNUM_W            = 23;

    localparam int DELTA_ONE         = 4096;
    localparam int DELTA_SHIFT       = 12;
    localparam int ALPHA_TOP         = 100;

    localparam int DIV_STEPS         = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HUE_SHIFT,
        CFG_SAT_DELTA,
        CFG_LIT_DELTA,
        CFG_ALPHA_DELTA
    } t_cfg_idx;

endpackage

// ===== hdl/hpa_div.sv =====
// ----------------------------------------------------------------------------
// hpa_div
// Pipelined restoring divider, ceil(QUO_W/STAGES) quotient bits per register stage.
// ----------------------------------------------------------------------------
module hpa_div #(
    parameter int NUM_W  = hpa_pkg::HNUM_W,
    parameter int DEN_W  = hpa_pkg::PIX_W,
    parameter int QUO_W  = hpa_pkg::FRACTION_BITS_DEF + 1,
    parameter int STAGES = (hpa_pkg::FRACTION_BITS_DEF + hpa_pkg::DIV_STEPS)
                           / hpa_pkg::DIV_STEPS
) (
    input  logic              i_clk,
    input  logic [STAGES-1:0] i_en,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    output logic [QUO_W-1:0]  o_quo
);

    localparam int STEP_N = (QUO_W + STAGES - 1) / STAGES;

    logic [DEN_W-1:0] r_rem [STAGES];
    logic [DEN_W-1:0] r_den [STAGES];
    logic [QUO_W-1:0] r_sh  [STAGES];
    logic [NUM_W-1:0] w_top;

    assign w_top = i_num >> QUO_W;

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [DEN_W-1:0] w_rem;
        logic [DEN_W-1:0] w_den;
        logic [QUO_W-1:0] w_sh;
        logic [DEN_W-1:0] n_rem;
        logic [QUO_W-1:0] n_sh;

        if (k == 0) begin : g_head
            assign w_rem = w_top[DEN_W-1:0];
            assign w_den = i_den;
            assign w_sh  = i_num[QUO_W-1:0];
        end else begin : g_body
            assign w_rem = r_rem[k-1];
            assign w_den = r_den[k-1];
            assign w_sh  = r_sh[k-1];
        end

        always_comb begin
            logic [DEN_W:0] v_try;
            n_rem = w_rem;
            n_sh  = w_sh;
            v_try = '0;
            for (int j = 0; j < STEP_N; j++) begin
                if (k * STEP_N + j < QUO_W) begin
                    v_try = {n_rem, n_sh[QUO_W-1]};
                    n_sh  = n_sh << 1;
                    if (v_try >= {1'b0, w_den}) begin
                        v_try   = v_try - {1'b0, w_den};
                        n_sh[0] = 1'b1;
                    end
                    n_rem = v_try[DEN_W-1:0];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_rem[k] <= n_rem;
                r_den[k] <= w_den;
                r_sh[k]  <= n_sh;
            end
        end
    end

    assign o_quo = r_sh[STAGES-1];

endmodule

// ===== hdl/hsla_pixel_adjust_core.sv =====
// ----------------------------------------------------------------------------
// hsla_pixel_adjust_core
// RGBA pixel adjust: RGB to HSL, hue shift, saturation, lightness and alpha
// scaling, then back to RGB, in a fully pipelined fixed-point datapath.
// ----------------------------------------------------------------------------
// One pixel beat is taken every clock while the output is not stalled. The
// pipeline depth is set by the hue and saturation dividers, which resolve
// ceil(QUO_W/STAGES) quotient bits per stage. A stalled output holds the pipe
// stage by stage, so empty stages keep filling. Configuration writes are
// taken every cycle and must only be made while no pixel is in flight.
module hsla_pixel_adjust_core #(
    parameter int FRACTION_BITS = hpa_pkg::FRACTION_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [hpa_pkg::PIX_W-1:0]     i_red_in,
    input  logic [hpa_pkg::PIX_W-1:0]     i_green_in,
    input  logic [hpa_pkg::PIX_W-1:0]     i_blue_in,
    input  logic [hpa_pkg::PIX_W-1:0]     i_alpha_in,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [hpa_pkg::PIX_W-1:0]     o_red_out,
    output logic [hpa_pkg::PIX_W-1:0]     o_green_out,
    output logic [hpa_pkg::PIX_W-1:0]     o_blue_out,
    output logic [hpa_pkg::PIX_W-1:0]     o_alpha_out,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [hpa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [hpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import hpa_pkg::*;

    localparam int F      = FRACTION_BITS;
    localparam int NS     = (F + DIV_STEPS) / DIV_STEPS;
    localparam int Q      = NS + 1;
    localparam int L      = NS + 7;
    localparam int LM_SH  = 19;
    localparam int LM_W   = F + 11;
    localparam int R15_SH = F + 8;
    localparam int R15_W  = F + 5;
    localparam int TT_W   = 12;

    localparam logic [F:0]       ONE = {1'b1, {F{1'b0}}};
    localparam logic [LM_W-1:0]  LM  =
        LM_W'(((64'd1 << (F + LM_SH)) + 64'd509) / 64'd510);
    localparam logic [R15_W-1:0] R15 =
        R15_W'(((64'd1 << R15_SH) + 64'd14) / 64'd15);
    localparam int CH_OFF [3] = '{2 * HUE_SIXTH, 0, -2 * HUE_SIXTH};

    function automatic logic [F:0] fx_scale(
        input logic [F:0]           x,
        input logic signed [16:0]   dl,
        input logic signed [17:0]   fac,
        input logic [F+17:0]        prod
    );
        logic [F+5:0] y;
        y = prod[DELTA_SHIFT +: F+6];
        if (dl == '0) begin
            fx_scale = x;
        end else if (fac <= 0) begin
            fx_scale = '0;
        end else if (y > (F+6)'(ONE)) begin
            fx_scale = ONE;
        end else begin
            fx_scale = y[F:0];
        end
    endfunction

    // configuration
    logic signed [15:0] r_hue_shift;
    logic signed [16:0] r_sat_delta;
    logic signed [16:0] r_lit_delta;
    logic signed [16:0] r_alpha_delta;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_shift   <= '0;
            r_sat_delta   <= '0;
            r_lit_delta   <= '0;
            r_alpha_delta <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_HUE_SHIFT:   r_hue_shift   <= i_cfg_data[15:0];
                CFG_SAT_DELTA:   r_sat_delta   <= i_cfg_data;
                CFG_LIT_DELTA:   r_lit_delta   <= i_cfg_data;
                CFG_ALPHA_DELTA: r_alpha_delta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // pipe control
    logic [L:0]   r_v;
    logic [L+1:0] w_en;

    always_comb begin
        w_en[L+1] = !i_stall;
        for (int k = L; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_valid;
            end
            for (int k = 1; k <= L; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_stall = !w_en[0];
    assign o_valid = r_v[L];

    // original pixel travels alongside
    logic [4*PIX_W-1:0] r_pix [L];

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pix[0] <= {i_red_in, i_green_in, i_blue_in, i_alpha_in};
        end
        for (int k = 1; k < L; k++) begin
            if (w_en[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    // stage 1: max, min, hue numerator, saturation divisor
    logic [PIX_W-1:0]         w_r, w_g, w_b, w_mx, w_mn, w_d, w_den;
    logic [PIX_W:0]           w_sum;
    logic [10:0]              w_id;
    logic signed [9:0]        w_f;
    logic signed [12:0]       w_idf;
    logic [HNUM_W-1:0]        w_hnum;

    always_comb begin
        w_r  = r_pix[0][3*PIX_W +: PIX_W];
        w_g  = r_pix[0][2*PIX_W +: PIX_W];
        w_b  = r_pix[0][PIX_W +: PIX_W];
        w_mx = w_r;
        w_mn = w_r;
        if (w_g > w_mx) w_mx = w_g;
        if (w_b > w_mx) w_mx = w_b;
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
        w_d   = w_mx - w_mn;
        w_sum = {1'b0, w_mx} + {1'b0, w_mn};
        if (w_r == w_mn) begin
            w_id = 11'(w_d) * 11'd3;
            w_f  = $signed({2'b0, w_g}) - $signed({2'b0, w_b});
        end else if (w_g == w_mn) begin
            w_id = 11'(w_d) * 11'd5;
            w_f  = $signed({2'b0, w_b}) - $signed({2'b0, w_r});
        end else begin
            w_id = 11'(w_d);
            w_f  = $signed({2'b0, w_r}) - $signed({2'b0, w_g});
        end
        w_idf  = $signed({2'b0, w_id}) - 13'(w_f);
        w_hnum = HNUM_W'(w_idf[10:0]) * HNUM_W'(HUE_SIXTH);
        w_den  = (w_sum <= 9'd255) ? w_sum[PIX_W-1:0] : PIX_W'(9'd510 - w_sum);
    end

    logic [HNUM_W-1:0] r_hnum1;
    logic [PIX_W-1:0]  r_den1;
    logic [PIX_W-1:0]  r_d1;
    logic [PIX_W:0]    r_sum1;
    logic              r_dz1;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_hnum1 <= w_hnum;
            r_den1  <= w_den;
            r_d1    <= w_d;
            r_sum1  <= w_sum;
            r_dz1   <= (w_d == '0);
        end
    end

    // stages 2 .. Q: dividers, lightness alongside
    logic [HUE_W-1:0] w_hq;
    logic [F:0]       w_sq;

    hpa_div #(
        .NUM_W  (HNUM_W),
        .DEN_W  (PIX_W),
        .QUO_W  (HUE_W),
        .STAGES (NS)
    ) u_hue_div (
        .i_clk  (i_clk),
        .i_en   (w_en[Q:2]),
        .i_num  (r_hnum1),
        .i_den  (r_d1),
        .o_quo  (w_hq)
    );

    hpa_div #(
        .NUM_W  (F + PIX_W),
        .DEN_W  (PIX_W),
        .QUO_W  (F + 1),
        .STAGES (NS)
    ) u_sat_div (
        .i_clk  (i_clk),
        .i_en   (w_en[Q:2]),
        .i_num  ({r_d1, {F{1'b0}}}),
        .i_den  (r_den1),
        .o_quo  (w_sq)
    );

    logic [F+LM_W+PIX_W:0] w_lprod;
    logic [F:0]            r_l_sb  [NS];
    logic                  r_dz_sb [NS];

    assign w_lprod = (F+LM_W+PIX_W+1)'(r_sum1) * (F+LM_W+PIX_W+1)'(LM);

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_l_sb[0]  <= w_lprod[LM_SH +: F+1];
            r_dz_sb[0] <= r_dz1;
        end
        for (int j = 1; j < NS; j++) begin
            if (w_en[2+j]) begin
                r_l_sb[j]  <= r_l_sb[j-1];
                r_dz_sb[j] <= r_dz_sb[j-1];
            end
        end
    end

    // stage Q+1: hue wrap and shift, scale products
    logic [HUE_W-1:0]   w_h0, w_h1;
    logic [F:0]         w_s0;
    logic signed [17:0] w_hs;
    logic signed [17:0] w_fs, w_fl, w_fa;
    logic [F+17:0]      w_ps, w_pl;
    logic [24:0]        w_pa;

    always_comb begin
        if (r_dz_sb[NS-1]) begin
            w_h0 = '0;
            w_s0 = '0;
        end else begin
            w_h0 = (w_hq >= HUE_W'(HUE_TURN)) ? w_hq - HUE_W'(HUE_TURN) : w_hq;
            w_s0 = w_sq;
        end
        w_hs = $signed({3'b0, w_h0}) + 18'(r_hue_shift);
        if (w_hs < 0) w_hs = w_hs + $signed(18'(HUE_TURN));
        if (w_hs < 0) w_hs = w_hs + $signed(18'(HUE_TURN));
        if (w_hs >= $signed(18'(HUE_TURN))) w_hs = w_hs - $signed(18'(HUE_TURN));
        if (w_hs >= $signed(18'(HUE_TURN))) w_hs = w_hs - $signed(18'(HUE_TURN));
        w_h1 = (r_hue_shift != '0) ? w_hs[HUE_W-1:0] : w_h0;
        w_fs = 18'(r_sat_delta) + $signed(18'(DELTA_ONE));
        w_fl = 18'(r_lit_delta) + $signed(18'(DELTA_ONE));
        w_fa = 18'(r_alpha_delta) + $signed(18'(DELTA_ONE));
        w_ps = (F+18)'(w_s0) * (F+18)'(w_fs[16:0]);
        w_pl = (F+18)'(r_l_sb[NS-1]) * (F+18)'(w_fl[16:0]);
        w_pa = 25'(r_pix[Q][0 +: PIX_W]) * 25'(w_fa[16:0]);
    end

    logic [HUE_W-1:0] r_h1;
    logic [F:0]       r_s0, r_l0;
    logic [F+17:0]    r_ps, r_pl;
    logic [24:0]      r_pa;

    always_ff @(posedge i_clk) begin
        if (w_en[Q+1]) begin
            r_h1 <= w_h1;
            r_s0 <= w_s0;
            r_l0 <= r_l_sb[NS-1];
            r_ps <= w_ps;
            r_pl <= w_pl;
            r_pa <= w_pa;
        end
    end

    // stage Q+2: clamps, l*s product
    logic [F:0]         w_s1, w_l1;
    logic [12:0]        w_ay;
    logic [PIX_W-1:0]   w_a1;
    logic [2*F+1:0]     w_ls;

    always_comb begin
        w_s1 = fx_scale(r_s0, r_sat_delta, w_fs, r_ps);
        w_l1 = fx_scale(r_l0, r_lit_delta, w_fl, r_pl);
        w_ay = r_pa[DELTA_SHIFT +: 13];
        if (r_alpha_delta == '0) begin
            w_a1 = r_pix[Q+1][0 +: PIX_W];
        end else if (w_fa <= 0) begin
            w_a1 = '0;
        end else if (w_ay > 13'(ALPHA_TOP)) begin
            w_a1 = PIX_W'(ALPHA_TOP);
        end else begin
            w_a1 = w_ay[PIX_W-1:0];
        end
        w_ls = (2*F+2)'(w_l1) * (2*F+2)'(w_s1);
    end

    logic [HUE_W-1:0] r_h2;
    logic [F:0]       r_l1, r_s1;
    logic [2*F+1:0]   r_ls;
    logic [PIX_W-1:0] r_af [Q+2:L-1];

    always_ff @(posedge i_clk) begin
        if (w_en[Q+2]) begin
            r_h2 <= r_h1;
            r_l1 <= w_l1;
            r_s1 <= w_s1;
            r_ls <= w_ls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[Q+2]) begin
            r_af[Q+2] <= w_a1;
        end
        for (int k = Q + 3; k < L; k++) begin
            if (w_en[k]) begin
                r_af[k] <= r_af[k-1];
            end
        end
    end

    // stage Q+3: q, p and channel positions
    logic [F+1:0]        w_lsh;
    logic [F+2:0]        w_q;
    logic signed [F+3:0] w_p;
    logic [F:0]          w_pf, w_diff;
    logic signed [16:0]  w_t  [3];
    logic [TT_W-1:0]     w_tt [3];

    always_comb begin
        w_lsh = r_ls[F +: F+2];
        if ({r_l1, 1'b0} < (F+2)'(ONE)) begin
            w_q = (F+3)'(r_l1) + (F+3)'(w_lsh);
        end else begin
            w_q = (F+3)'(r_l1) + (F+3)'(r_s1) - (F+3)'(w_lsh);
        end
        w_p = $signed((F+4)'({r_l1, 1'b0})) - $signed((F+4)'(w_q));
        if (w_p < 0) w_p = '0;
        if (w_p > $signed((F+4)'(w_q))) w_p = $signed((F+4)'(w_q));
        w_pf   = w_p[F:0];
        w_diff = w_q[F:0] - w_pf;
        for (int c = 0; c < 3; c++) begin
            w_t[c] = $signed({2'b0, r_h2}) + 17'(CH_OFF[c]);
            if (w_t[c] < 0) begin
                w_t[c] = w_t[c] + $signed(17'(HUE_TURN));
            end else if (w_t[c] > $signed(17'(HUE_TURN))) begin
                w_t[c] = w_t[c] - $signed(17'(HUE_TURN));
            end
            if (w_t[c] < HUE_SIXTH) begin
                w_tt[c] = TT_W'(w_t[c]);
            end else if (w_t[c] < 3 * HUE_SIXTH) begin
                w_tt[c] = TT_W'(HUE_SIXTH);
            end else if (w_t[c] < 4 * HUE_SIXTH) begin
                w_tt[c] = TT_W'(4 * HUE_SIXTH - w_t[c]);
            end else begin
                w_tt[c] = '0;
            end
        end
    end

    logic [F:0]      r_p3, r_diff3;
    logic [TT_W-1:0] r_tt3 [3];

    always_ff @(posedge i_clk) begin
        if (w_en[Q+3]) begin
            r_p3    <= w_pf;
            r_diff3 <= w_diff;
            for (int c = 0; c < 3; c++) begin
                r_tt3[c] <= w_tt[c];
            end
        end
    end

    // stage Q+4: ramp products
    logic [F+12:0] r_prod4 [3];
    logic [F:0]    r_p4;

    always_ff @(posedge i_clk) begin
        if (w_en[Q+4]) begin
            r_p4 <= r_p3;
            for (int c = 0; c < 3; c++) begin
                r_prod4[c] <= (F+13)'(r_diff3) * (F+13)'(r_tt3[c]);
            end
        end
    end

    // stage Q+5: divide by one sixth turn
    logic [2*F+9:0] w_qm [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_qm[c] = (2*F+10)'(r_prod4[c][8 +: F+5]) * (2*F+10)'(R15);
        end
    end

    logic [F:0] r_quo5 [3];
    logic [F:0] r_p5;

    always_ff @(posedge i_clk) begin
        if (w_en[Q+5]) begin
            r_p5 <= r_p4;
            for (int c = 0; c < 3; c++) begin
                r_quo5[c] <= w_qm[c][R15_SH +: F+1];
            end
        end
    end

    // stage L: back to 8 bits, output register
    logic [F+1:0]     w_v   [3];
    logic [F+10:0]    w_v255 [3];
    logic [PIX_W-1:0] w_o   [3];
    logic             w_bypass;

    always_comb begin
        w_bypass = (r_hue_shift == '0) && (r_sat_delta == '0) &&
                   (r_lit_delta == '0) && (r_alpha_delta == '0);
        for (int c = 0; c < 3; c++) begin
            w_v[c]    = (F+2)'(r_p5) + (F+2)'(r_quo5[c]);
            w_v255[c] = (F+11)'(w_v[c]) * (F+11)'(255);
            if (w_v255[c][F +: 11] > 11'd255) begin
                w_o[c] = '1;
            end else begin
                w_o[c] = w_v255[c][F +: PIX_W];
            end
        end
    end

    logic [PIX_W-1:0] r_out [3];
    logic [PIX_W-1:0] r_aout;

    always_ff @(posedge i_clk) begin
        if (w_en[L]) begin
            for (int c = 0; c < 3; c++) begin
                r_out[c] <= w_bypass ? r_pix[L-1][(3-c)*PIX_W +: PIX_W] : w_o[c];
            end
            r_aout <= w_bypass ? r_pix[L-1][0 +: PIX_W] : r_af[L-1];
        end
    end

    assign o_red_out   = r_out[0];
    assign o_green_out = r_out[1];
    assign o_blue_out  = r_out[2];
    assign o_alpha_out = r_aout;

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> ((&r_v) && i_stall))
        else $error("input stalled with a bubble in the pipe");

    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_v[0])
        else $error("accepted beat not captured");

    a_head_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !w_en[1]) |=> (r_v[0] && $stable(r_pix[0])))
        else $error("held beat lost in first stage");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[1] && !r_dz1) |-> (r_den1 != '0))
        else $error("zero divisor on a chromatic pixel");

endmodule
